### rtl/core/pgdc_pkg.sv
package pgdc_pkg;

   // Packet sections, one-hot.
   typedef enum logic [7:0] {
      SEC_HUNT    = 8'b0000_0001,
      SEC_HEADER  = 8'b0000_0010,
      SEC_ODD_HI  = 8'b0000_0100,
      SEC_ODD_DAT = 8'b0000_1000,
      SEC_GRP_HI  = 8'b0001_0000,
      SEC_GRP_DAT = 8'b0010_0000,
      SEC_CHK1    = 8'b0100_0000,
      SEC_CHK2    = 8'b1000_0000
   } section_type;

   typedef enum logic [2:0] {
      OUT_OK             = 3'd0,
      OUT_MISMATCH       = 3'd1,
      OUT_NO_START       = 3'd2,
      OUT_SHORT_HEADER   = 3'd3,
      OUT_SHORT_ODD      = 3'd4,
      OUT_SHORT_GROUP    = 3'd5,
      OUT_SHORT_CHECKSUM = 3'd6
   } outcome_type;

   localparam logic [7:0] START_MARK = 8'hC3;
   localparam logic [7:0] TOP_BIT    = 8'h80;
   localparam logic [6:0] LOW7       = 7'h7F;

   localparam logic [2:0] ODD_COUNT_POS = 3'd5;
   localparam logic [2:0] LAST_HDR_POS  = 3'd6;
   localparam logic [2:0] LAST_GRP_POS  = 3'd6;
   localparam logic [2:0] MAX_POS       = 3'd7;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       end_of_buffer;
   } word_type;

   typedef struct packed {
      outcome_type outcome;
      logic [7:0]  residue;
   } result_type;

endpackage

### rtl/core/packet_group_decode_checksum_core.sv
// A word accepted into the input register is decoded from there, and its result, if it has
// one, is loaded into the result register and presented on rsp_valid from that register.
// Throughput: one word per cycle; a result held while rsp_ready is low stalls the input.
// Reset (synchronous, active high) empties the input and result registers and returns the
// decoder to hunting for the start byte with a cleared checksum.
module packet_group_decode_checksum_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_wire_byte,
   input  logic       req_end_of_buffer,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_outcome,
   output logic [7:0] rsp_residue
);

   pgdc_pkg::word_type   req_word;
   pgdc_pkg::word_type   word;
   pgdc_pkg::result_type step_result;
   pgdc_pkg::result_type rsp_result;
   logic                 word_valid;
   logic                 space;
   logic                 advance;
   logic                 emit;

   assign req_word.wire_byte     = req_wire_byte;
   assign req_word.end_of_buffer = req_end_of_buffer;

   // A word moves through the decoder only when the result register can take its result.
   assign advance = word_valid && space;

   pgdc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   pgdc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .word    (word),
      .emit    (emit),
      .result  (step_result)
   );

   pgdc_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && emit),
      .load_result (step_result),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (rsp_result)
   );

   assign rsp_outcome = rsp_result.outcome;
   assign rsp_residue = rsp_result.residue;

endmodule

### rtl/core/pgdc_in_stage.sv
module pgdc_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pgdc_pkg::word_type  req_word,
   input  logic                advance,
   output logic                word_valid,
   output pgdc_pkg::word_type  word
);

   logic               valid_ff;
   logic               valid_in;
   pgdc_pkg::word_type word_ff;

   // The register may refill in the same cycle that its word moves on.
   assign req_ready  = !valid_ff || advance;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !advance);
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

endmodule

### rtl/core/pgdc_engine.sv
module pgdc_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  pgdc_pkg::word_type   word,
   output logic                 emit,
   output pgdc_pkg::result_type result
);

   pgdc_pkg::section_type section_ff, section_in;
   logic [7:0] sum_ff, sum_in;
   logic [2:0] position_ff, position_in;
   logic [6:0] odd_total_ff, odd_total_in;
   logic [6:0] groups_left_ff, groups_left_in;
   logic [6:0] high_bits_ff, high_bits_in;
   logic [7:0] first_check_ff, first_check_in;
   logic       reported_ff, reported_in;

   logic [7:0] b;
   logic       last;
   logic [7:0] restored;
   logic [7:0] pkt_sum;
   logic [7:0] res;

   function automatic logic [7:0] restore(input logic [7:0] w, input logic [2:0] idx,
                                          input logic [6:0] hb);
      logic hi;
      hi = 1'b0;
      if (idx < pgdc_pkg::MAX_POS) begin
         hi = hb[3'd6 - idx];
      end
      return {hi, w[6:0] & pgdc_pkg::LOW7};
   endfunction

   assign b        = word.wire_byte;
   assign last     = word.end_of_buffer;
   assign restored = restore(b, position_ff, high_bits_ff);
   assign pkt_sum  = {b[6:0], 1'b1} & first_check_ff;
   assign res      = sum_ff ^ pkt_sum;

   always_comb begin
      section_in     = section_ff;
      sum_in         = sum_ff;
      position_in    = position_ff;
      odd_total_in   = odd_total_ff;
      groups_left_in = groups_left_ff;
      high_bits_in   = high_bits_ff;
      first_check_in = first_check_ff;
      reported_in    = reported_ff;
      emit           = 1'b0;
      result.outcome = pgdc_pkg::OUT_OK;
      result.residue = '0;

      if (!reported_ff) begin
         unique case (section_ff)
            pgdc_pkg::SEC_HUNT: begin
               if (b == pgdc_pkg::START_MARK) begin
                  section_in  = pgdc_pkg::SEC_HEADER;
                  position_in = '0;
               end
            end
            pgdc_pkg::SEC_HEADER: begin
               sum_in = sum_ff ^ (b | pgdc_pkg::TOP_BIT);
               if (position_ff == pgdc_pkg::ODD_COUNT_POS) begin
                  odd_total_in = b[6:0];
               end
               if (position_ff >= pgdc_pkg::LAST_HDR_POS) begin
                  groups_left_in = b[6:0];
                  position_in    = '0;
                  if (odd_total_ff != '0) begin
                     section_in = pgdc_pkg::SEC_ODD_HI;
                  end else if (b[6:0] != '0) begin
                     section_in = pgdc_pkg::SEC_GRP_HI;
                  end else begin
                     section_in = pgdc_pkg::SEC_CHK1;
                  end
               end else begin
                  position_in = position_ff + 3'd1;
               end
            end
            pgdc_pkg::SEC_ODD_HI: begin
               high_bits_in = b[6:0];
               position_in  = '0;
               section_in   = pgdc_pkg::SEC_ODD_DAT;
            end
            pgdc_pkg::SEC_ODD_DAT: begin
               sum_in = sum_ff ^ restored;
               // The position saturates so that late odd bytes get a clear top bit.
               if (position_ff < pgdc_pkg::MAX_POS) begin
                  position_in = position_ff + 3'd1;
               end
               odd_total_in = odd_total_ff - 7'd1;
               if (odd_total_in == '0) begin
                  section_in = (groups_left_ff != '0) ? pgdc_pkg::SEC_GRP_HI
                                                      : pgdc_pkg::SEC_CHK1;
               end
            end
            pgdc_pkg::SEC_GRP_HI: begin
               high_bits_in = b[6:0];
               position_in  = '0;
               section_in   = pgdc_pkg::SEC_GRP_DAT;
            end
            pgdc_pkg::SEC_GRP_DAT: begin
               sum_in = sum_ff ^ restored;
               if (position_ff >= pgdc_pkg::LAST_GRP_POS) begin
                  position_in    = '0;
                  groups_left_in = groups_left_ff - 7'd1;
                  section_in     = (groups_left_in != '0) ? pgdc_pkg::SEC_GRP_HI
                                                          : pgdc_pkg::SEC_CHK1;
               end else begin
                  position_in = position_ff + 3'd1;
               end
            end
            pgdc_pkg::SEC_CHK1: begin
               first_check_in = b;
               section_in     = pgdc_pkg::SEC_CHK2;
            end
            pgdc_pkg::SEC_CHK2: begin
               emit           = 1'b1;
               reported_in    = 1'b1;
               result.outcome = (res != '0) ? pgdc_pkg::OUT_MISMATCH : pgdc_pkg::OUT_OK;
               result.residue = res;
            end
            default: begin
               section_in = pgdc_pkg::SEC_HUNT;
            end
         endcase

         // A buffer that ends early reports the section it was cut off in.
         if (last && !emit) begin
            emit = 1'b1;
            unique case (section_in)
               pgdc_pkg::SEC_HUNT:   result.outcome = pgdc_pkg::OUT_NO_START;
               pgdc_pkg::SEC_HEADER: result.outcome = pgdc_pkg::OUT_SHORT_HEADER;
               pgdc_pkg::SEC_ODD_HI,
               pgdc_pkg::SEC_ODD_DAT: result.outcome = pgdc_pkg::OUT_SHORT_ODD;
               pgdc_pkg::SEC_GRP_HI,
               pgdc_pkg::SEC_GRP_DAT: result.outcome = pgdc_pkg::OUT_SHORT_GROUP;
               default:              result.outcome = pgdc_pkg::OUT_SHORT_CHECKSUM;
            endcase
         end
      end

      if (last) begin
         section_in     = pgdc_pkg::SEC_HUNT;
         sum_in         = '0;
         position_in    = '0;
         odd_total_in   = '0;
         groups_left_in = '0;
         high_bits_in   = '0;
         first_check_in = '0;
         reported_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff     <= pgdc_pkg::SEC_HUNT;
         sum_ff         <= '0;
         position_ff    <= '0;
         odd_total_ff   <= '0;
         groups_left_ff <= '0;
         high_bits_ff   <= '0;
         first_check_ff <= '0;
         reported_ff    <= 1'b0;
      end else if (step_en) begin
         section_ff     <= section_in;
         sum_ff         <= sum_in;
         position_ff    <= position_in;
         odd_total_ff   <= odd_total_in;
         groups_left_ff <= groups_left_in;
         high_bits_ff   <= high_bits_in;
         first_check_ff <= first_check_in;
         reported_ff    <= reported_in;
      end
   end

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      step_en && last |=> section_ff == pgdc_pkg::SEC_HUNT && !reported_ff && sum_ff == '0)
      else $error("packet state not cleared after the last word");

   a_single_report: assert property (@(posedge clock) disable iff (reset)
      emit |-> !reported_ff)
      else $error("second result for one packet");

   a_report_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(reported_ff) |-> $past(step_en && emit && section_ff == pgdc_pkg::SEC_CHK2))
      else $error("reported flag set without a checksum result");

   a_short_residue: assert property (@(posedge clock) disable iff (reset)
      emit && result.outcome != pgdc_pkg::OUT_OK && result.outcome != pgdc_pkg::OUT_MISMATCH
      |-> result.residue == '0 && last)
      else $error("short outcome with nonzero residue or without the last flag");

endmodule

### rtl/core/pgdc_out_stage.sv
module pgdc_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  pgdc_pkg::result_type load_result,
   output logic                 space,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pgdc_pkg::result_type rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   pgdc_pkg::result_type result_ff;

   // Room for a new result when empty or when the held one leaves this cycle.
   assign space      = !valid_ff || rsp_ready;
   assign valid_in   = load || (valid_ff && !rsp_ready);
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

endmodule

### bench/packet_group_decode_checksum_core_test.sv
`timescale 1ns / 100ps

module packet_group_decode_checksum_core_test;

   localparam int HOLD_CYCLES     = 300;
   localparam int WORDS_PER_PHASE = 475;
   localparam int SETTLE_CYCLES   = 20;
   localparam int DIRECTED_COUNT  = 23;

   // Sender idle and receiver stall odds, in percent, for each random phase.
   localparam int SEND_IDLE [0:3]  = '{0, 87, 0, 8};
   localparam int RECV_STALL [0:3] = '{0, 0, 87, 8};

   typedef struct packed {
      logic [7:0]            wire_byte;
      logic                  last;
      logic                  typed;
      pgdc_pkg::outcome_type outcome;
      logic [7:0]            residue;
   } stim_row_type;

   // Rows with typed set carry their result written out by hand.
   localparam stim_row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      '{8'h00, 1'b1, 1'b1, pgdc_pkg::OUT_NO_START,       8'h00},
      '{8'hC3, 1'b1, 1'b1, pgdc_pkg::OUT_SHORT_HEADER,   8'h00},
      '{8'hFF, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'hC3, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'hFF, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h01, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h7F, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h80, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'hFF, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'hC0, 1'b0, 1'b1, pgdc_pkg::OUT_OK,             8'h00},
      '{8'hC3, 1'b1, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'hC3, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h00, 1'b0, 1'b0, pgdc_pkg::OUT_OK,             8'h00},
      '{8'h12, 1'b1, 1'b1, pgdc_pkg::OUT_SHORT_CHECKSUM, 8'h00}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_wire_byte = 8'h00;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_outcome;
   logic [7:0] rsp_residue;

   logic                 row_typed = 1'b0;
   pgdc_pkg::result_type row_result = '0;

   pgdc_pkg::result_type due_results[$];
   logic [7:0]           frame_bytes[$];
   int                   fault_count = 0;
   int                   words_sent = 0;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   logic                 hold_toggle = 1'b0;
   logic                 hold_seen = 1'b0;
   int                   hold_left = 0;

   // Decoder state as the block should hold it.
   pgdc_pkg::section_type sect;
   logic [7:0]            csum;
   logic [2:0]            pos;
   logic [6:0]            odd_left;
   logic [6:0]            grp_left;
   logic [6:0]            hi7;
   logic [7:0]            chk1;
   logic                  report_done;

   packet_group_decode_checksum_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_wire_byte     (req_wire_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_outcome       (rsp_outcome),
      .rsp_residue       (rsp_residue)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("packet_group_decode_checksum_core test failed");
      $finish;
   end

   function void clear_decoder();
      sect        = pgdc_pkg::SEC_HUNT;
      csum        = 8'h00;
      pos         = 3'd0;
      odd_left    = 7'd0;
      grp_left    = 7'd0;
      hi7         = 7'd0;
      chk1        = 8'h00;
      report_done = 1'b0;
   endfunction

   function pgdc_pkg::section_type after_odd_section();
      return (grp_left != 7'd0) ? pgdc_pkg::SEC_GRP_HI : pgdc_pkg::SEC_CHK1;
   endfunction

   // Advances the decoder by one word; returns 1 when the word yields a result.
   function automatic bit decode_word(input logic [7:0] b, input logic last,
                                      output pgdc_pkg::result_type r);
      logic [7:0] restored;
      logic [7:0] res;
      bit         got;
      got = 1'b0;
      r = '0;
      if (report_done) begin
         if (last) clear_decoder();
         return 1'b0;
      end
      // Odd bytes past the seventh have no high bit to borrow.
      restored = {(pos < pgdc_pkg::MAX_POS) ? hi7[6 - pos] : 1'b0, b[6:0]};
      unique case (sect)
         pgdc_pkg::SEC_HUNT: begin
            if (b == pgdc_pkg::START_MARK) begin
               sect = pgdc_pkg::SEC_HEADER;
               pos  = 3'd0;
            end
         end
         pgdc_pkg::SEC_HEADER: begin
            csum = csum ^ (b | pgdc_pkg::TOP_BIT);
            if (pos == pgdc_pkg::ODD_COUNT_POS) odd_left = b[6:0];
            if (pos >= pgdc_pkg::LAST_HDR_POS) begin
               grp_left = b[6:0];
               pos      = 3'd0;
               sect     = (odd_left != 7'd0) ? pgdc_pkg::SEC_ODD_HI : after_odd_section();
            end else begin
               pos = pos + 3'd1;
            end
         end
         pgdc_pkg::SEC_ODD_HI: begin
            hi7  = b[6:0];
            pos  = 3'd0;
            sect = pgdc_pkg::SEC_ODD_DAT;
         end
         pgdc_pkg::SEC_ODD_DAT: begin
            csum = csum ^ restored;
            if (pos < pgdc_pkg::MAX_POS) pos = pos + 3'd1;
            odd_left = odd_left - 7'd1;
            if (odd_left == 7'd0) sect = after_odd_section();
         end
         pgdc_pkg::SEC_GRP_HI: begin
            hi7  = b[6:0];
            pos  = 3'd0;
            sect = pgdc_pkg::SEC_GRP_DAT;
         end
         pgdc_pkg::SEC_GRP_DAT: begin
            csum = csum ^ restored;
            if (pos >= pgdc_pkg::LAST_GRP_POS) begin
               pos      = 3'd0;
               grp_left = grp_left - 7'd1;
               sect     = after_odd_section();
            end else begin
               pos = pos + 3'd1;
            end
         end
         pgdc_pkg::SEC_CHK1: begin
            chk1 = b;
            sect = pgdc_pkg::SEC_CHK2;
         end
         default: begin
            res         = csum ^ ({b[6:0], 1'b1} & chk1);
            r.outcome   = (res != 8'h00) ? pgdc_pkg::OUT_MISMATCH : pgdc_pkg::OUT_OK;
            r.residue   = res;
            report_done = 1'b1;
            got         = 1'b1;
         end
      endcase
      if (last) begin
         if (!got) begin
            unique case (sect)
               pgdc_pkg::SEC_HUNT:    r.outcome = pgdc_pkg::OUT_NO_START;
               pgdc_pkg::SEC_HEADER:  r.outcome = pgdc_pkg::OUT_SHORT_HEADER;
               pgdc_pkg::SEC_ODD_HI,
               pgdc_pkg::SEC_ODD_DAT: r.outcome = pgdc_pkg::OUT_SHORT_ODD;
               pgdc_pkg::SEC_GRP_HI,
               pgdc_pkg::SEC_GRP_DAT: r.outcome = pgdc_pkg::OUT_SHORT_GROUP;
               default:               r.outcome = pgdc_pkg::OUT_SHORT_CHECKSUM;
            endcase
            r.residue = 8'h00;
            got = 1'b1;
         end
         clear_decoder();
      end
      return got;
   endfunction

   always @(posedge clock) begin : watch_words
      pgdc_pkg::result_type got;
      pgdc_pkg::result_type want;
      bit                   has;
      if (!reset) begin
         if (req_valid && req_ready) begin
            has = decode_word(req_wire_byte, req_end_of_buffer, got);
            if (row_typed) due_results.push_back(row_result);
            else if (has) due_results.push_back(got);
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result: outcome %0d residue %h", rsp_outcome, rsp_residue);
               fault_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_outcome !== want.outcome) begin
                  $error("outcome: expected %0d, got %0d", want.outcome, rsp_outcome);
                  fault_count++;
               end
               if (rsp_residue !== want.residue) begin
                  $error("residue: expected %h, got %h", want.residue, rsp_residue);
                  fault_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
                            input pgdc_pkg::result_type typed_res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_wire_byte     <= b;
      req_end_of_buffer <= last;
      row_typed         <= typed;
      row_result        <= typed_res;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (due_results.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Mostly well-formed packets with random content; some noise and cut-off buffers.
   task automatic make_frame();
      int         odd_n;
      int         grp_n;
      int         keep;
      logic [7:0] s;
      logic [7:0] hb;
      logic [7:0] hdr;
      logic [7:0] r;
      logic [7:0] c1;
      logic [7:0] c2;
      frame_bytes.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(6, 1))
            frame_bytes.push_back(($urandom_range(3) == 0) ? pgdc_pkg::START_MARK
                                                           : 8'($urandom));
         return;
      end
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(3, 1)) frame_bytes.push_back(8'($urandom));
      odd_n = ($urandom_range(29) == 0) ? $urandom_range(127) : $urandom_range(10);
      grp_n = ($urandom_range(59) == 0) ? $urandom_range(127) : $urandom_range(3);
      frame_bytes.push_back(pgdc_pkg::START_MARK);
      s = 8'h00;
      for (int i = 0; i < 7; i++) begin
         hdr = 8'($urandom);
         if (i == 5) hdr[6:0] = 7'(odd_n);
         if (i == 6) hdr[6:0] = 7'(grp_n);
         s = s ^ (hdr | pgdc_pkg::TOP_BIT);
         frame_bytes.push_back(hdr);
      end
      if (odd_n != 0) begin
         hb = 8'($urandom);
         frame_bytes.push_back(hb);
         for (int i = 0; i < odd_n; i++) begin
            r = 8'($urandom);
            frame_bytes.push_back(r);
            s = s ^ {(i < 7) ? hb[6 - i] : 1'b0, r[6:0]};
         end
      end
      for (int g = 0; g < grp_n; g++) begin
         hb = 8'($urandom);
         frame_bytes.push_back(hb);
         for (int i = 0; i < 7; i++) begin
            r = 8'($urandom);
            frame_bytes.push_back(r);
            s = s ^ {hb[6 - i], r[6:0]};
         end
      end
      r = 8'($urandom);
      if ($urandom_range(1) == 1) begin
         // Pick check bytes whose rebuilt checksum equals the running sum.
         c1 = s[0] ? (s | (r & ~s)) : s;
         c2 = s[0] ? {r[7], s[7:1]} : {r[7], 7'h7F};
      end else begin
         c1 = r;
         c2 = 8'($urandom);
      end
      frame_bytes.push_back(c1);
      frame_bytes.push_back(c2);
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(4, 1)) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(5) == 0) begin
         keep = $urandom_range(frame_bytes.size(), 1);
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
   endtask

   initial begin
      int                   first;
      pgdc_pkg::result_type typed_res;
      clear_decoder();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         typed_res.outcome = DIRECTED_ROWS[i].outcome;
         typed_res.residue = DIRECTED_ROWS[i].residue;
         send_word(DIRECTED_ROWS[i].wire_byte, DIRECTED_ROWS[i].last,
                   DIRECTED_ROWS[i].typed, typed_res);
      end
      wait_for_results();

      // Hold the receiver off while one-word buffers keep coming, so the block backs up.
      hold_toggle <= ~hold_toggle;
      repeat (24) send_word(8'($urandom), 1'b1, 1'b0, '0);
      wait_for_results();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = SEND_IDLE[p];
         recv_stall_pct <= RECV_STALL[p];
         first = words_sent;
         while (words_sent - first < WORDS_PER_PHASE) begin
            make_frame();
            for (int i = 0; i < frame_bytes.size(); i++)
               send_word(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
         end
         wait_for_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         $error("%0d expected results never arrived", due_results.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("packet_group_decode_checksum_core test passed");
      end else begin
         $display("packet_group_decode_checksum_core test failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/pgdc_pkg.sv
rtl/core/pgdc_in_stage.sv
rtl/core/pgdc_engine.sv
rtl/core/pgdc_out_stage.sv
rtl/core/packet_group_decode_checksum_core.sv
bench/packet_group_decode_checksum_core_test.sv
